// ===== design/rstm_pkg.sv =====
// Shared constants and types for the range sample trimmed mean core.
`timescale 1ns / 1ps

package rstm_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int WINDOW_LEN = 5;
   localparam int COUNT_BITS = $clog2(WINDOW_LEN + 1);
   localparam int LIMIT_BITS = 10;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd500;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_MULT = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

// ===== design/rstm_cell.sv =====
// One slot of the sorted insertion chain.
`timescale 1ns / 1ps

module rstm_cell
   import rstm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic                   occupied,
   input  logic [SAMPLE_BITS-1:0] new_value,
   input  logic                   pass_in,
   input  logic [SAMPLE_BITS-1:0] left_value,
   output logic                   pass_out,
   output logic [SAMPLE_BITS-1:0] value
);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;
   logic                   below;

   assign below    = new_value < value_ff;
   assign pass_out = occupied && below;
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (load) begin
         if (pass_in) begin
            value_in = left_value;
         end else if (!occupied || below) begin
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== design/range_sample_trimmed_mean_core.sv =====
// Top level of the range sample trimmed mean core.
// Each accepted sample that passes the timeout, zero and limit checks is sorted into the cell chain at once.
// The fifth valid sample of a window starts a tail through the sum, multiply and emit states,
// during which busy is high; the result strobe is shown in the emit state.
// The receiver cannot stall, so a new sample is taken the cycle after the strobe.
// Synchronous active-high reset empties the window and sets the upper limit to 500 cm.
`timescale 1ns / 1ps

module range_sample_trimmed_mean_core
   import rstm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [SAMPLE_BITS-1:0] req_sample_cm,
   input  logic                   req_timed_out,
   output logic                   rsp_strobe,
   output logic [SAMPLE_BITS-1:0] rsp_average_cm,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LIMIT_BITS-1:0]  csr_upper_limit_cm
);

   localparam int SUM_BITS = SAMPLE_BITS + 2;
   localparam int RECIP_SHIFT = SUM_BITS + 2;
   localparam int RECIP_BITS = RECIP_SHIFT;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 3 + 1);
   localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

   state_type                state_ff;
   state_type                state_in;
   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;
   logic [LIMIT_BITS-1:0]    limit_ff;
   logic [SUM_BITS-1:0]      sum_ff;
   logic [PROD_BITS-1:0]     prod_ff;

   logic                     accept;
   logic                     load;
   logic                     last;
   logic [WINDOW_LEN-1:0]    occupied;
   logic [WINDOW_LEN-1:0]    pass;
   logic [SAMPLE_BITS-1:0]   cell_value [WINDOW_LEN];

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign load      = accept && !req_timed_out && (req_sample_cm != '0)
                      && (32'(req_sample_cm) < 32'(limit_ff));
   assign last      = load && (count_ff == COUNT_BITS'(WINDOW_LEN - 1));

   assign pass[0] = 1'b0;

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      assign occupied[i] = COUNT_BITS'(i) < count_ff;
      if (i < WINDOW_LEN - 1) begin : g_mid
         rstm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock      (clock),
            .load       (load),
            .occupied   (occupied[i]),
            .new_value  (req_sample_cm),
            .pass_in    (pass[i]),
            .left_value (cell_value[(i == 0) ? 0 : i - 1]),
            .pass_out   (pass[i+1]),
            .value      (cell_value[i])
         );
      end else begin : g_end
         rstm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock      (clock),
            .load       (load),
            .occupied   (occupied[i]),
            .new_value  (req_sample_cm),
            .pass_in    (pass[i]),
            .left_value (cell_value[i-1]),
            .pass_out   (),
            .value      (cell_value[i])
         );
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (last) begin
               count_in = '0;
               state_in = ST_SUM;
            end else if (load) begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_SUM:  state_in = ST_MULT;
         ST_MULT: state_in = ST_EMIT;
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_upper_limit_cm;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= SUM_BITS'(cell_value[1]) + SUM_BITS'(cell_value[2])
                 + SUM_BITS'(cell_value[3]);
      prod_ff <= PROD_BITS'(sum_ff) * PROD_BITS'(RECIP);
   end

   assign rsp_strobe     = (state_ff == ST_EMIT);
   assign rsp_average_cm = prod_ff[RECIP_SHIFT +: SAMPLE_BITS];

endmodule

// ===== design/rstm_checker.sv =====
// Port-level checks for the range sample trimmed mean core, bound to the top level.
`timescale 1ns / 1ps

module rstm_checker
   import rstm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   busy,
   input logic                   rsp_strobe,
   input logic [SAMPLE_BITS-1:0] rsp_average_cm
);

   a_strobe_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("Result word shown while the core is not busy.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("Result word not followed by an idle cycle.");

   a_nonzero_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_average_cm != '0)
      else $error("Result word holds a zero mean.");

   a_busy_length: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |=> busy ##1 (busy && rsp_strobe))
      else $error("Busy period does not end in a result word on its third cycle.");

endmodule

bind range_sample_trimmed_mean_core rstm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rstm_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_average_cm (rsp_average_cm)
);

// ===== verif/tb_range_sample_trimmed_mean_core.sv =====
// Self-checking testbench for the range sample trimmed mean core.
`timescale 1ns / 1ps

module tb_range_sample_trimmed_mean_core;
   import rstm_pkg::*;

   localparam int SB = SAMPLE_BITS_DEFAULT;
   localparam int N_ROWS = 27;
   localparam int N_PHASES = 7;
   localparam int WORDS_PER_PHASE = 63;

   typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [SB-1:0]   value;
      logic            timed_out;
      logic            has_average;
      logic [SB-1:0]   average;
   } stim_row_type;

   localparam stim_row_type DIRECTED [N_ROWS] = '{
      '{ROW_WORD,  10'd100,  1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd200,  1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd0,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd300,  1'b1, 1'b0, 10'd0},
      '{ROW_WORD,  10'd500,  1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd499,  1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1023, 1'b1, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd150,  1'b0, 1'b1, 10'd150},
      '{ROW_LIMIT, 10'd1023, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1023, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1022, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1022, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1022, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1022, 1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1022, 1'b0, 1'b1, 10'd1022},
      '{ROW_LIMIT, 10'd2,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd2,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1,    1'b0, 1'b1, 10'd1},
      '{ROW_LIMIT, 10'd0,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1,    1'b0, 1'b0, 10'd0},
      '{ROW_WORD,  10'd1023, 1'b0, 1'b0, 10'd0},
      '{ROW_LIMIT, 10'd500,  1'b0, 1'b0, 10'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [SB-1:0]         req_sample_cm;
   logic                  req_timed_out;
   logic                  rsp_strobe;
   logic [SB-1:0]         rsp_average_cm;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LIMIT_BITS-1:0] csr_upper_limit_cm;

   logic [SB-1:0]         window_cm [WINDOW_LEN];
   int                    held_count = 0;
   logic [LIMIT_BITS-1:0] limit_cm = LIMIT_RESET;
   logic [SB-1:0]         average_q [$];
   logic [SB-1:0]         expected_cm;
   int                    mismatch_count = 0;
   int                    taken_count = 0;

   range_sample_trimmed_mean_core #(
      .SAMPLE_BITS(SB)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_sample_cm     (req_sample_cm),
      .req_timed_out     (req_timed_out),
      .rsp_strobe        (rsp_strobe),
      .rsp_average_cm    (rsp_average_cm),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_upper_limit_cm(csr_upper_limit_cm)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Returns 1 when the sample completes a window; avg then holds the trimmed mean.
   function automatic logic take_sample(input logic [SB-1:0] s, input logic to,
                                        output logic [SB-1:0] avg);
      logic [SB-1:0] v [WINDOW_LEN];
      logic [SB-1:0] t;
      logic [SB+1:0] sum;
      avg = '0;
      if (to || s == '0 || s >= limit_cm)
         return 1'b0;
      taken_count++;
      window_cm[held_count] = s;
      held_count++;
      if (held_count < WINDOW_LEN)
         return 1'b0;
      held_count = 0;
      v = window_cm;
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
         for (int j = i + 1; j < WINDOW_LEN; j++) begin
            if (v[i] > v[j]) begin
               t = v[i];
               v[i] = v[j];
               v[j] = t;
            end
         end
      end
      sum = {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
      avg = SB'(sum / 3);
      return 1'b1;
   endfunction

   function automatic logic [SB-1:0] pick_sample();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (limit_cm <= 1)
         return SB'($urandom_range(0, 1023));
      if (r < 6)
         return '0;
      if (r < 16)
         return SB'($urandom_range(limit_cm, 1023));
      return SB'($urandom_range(1, limit_cm - 1));
   endfunction

   function automatic int pick_gap(input logic quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_word(input logic [SB-1:0] s, input logic to,
                            input logic has_average, input logic [SB-1:0] average);
      logic [SB-1:0] avg;
      req_sample_cm = s;
      req_timed_out = to;
      start = 1'b1;
      do @(posedge clock); while (busy);
      if (take_sample(s, to, avg))
         average_q.push_back(has_average ? average : avg);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         start = 1'b0;
         req_sample_cm = SB'($urandom);
         req_timed_out = 1'($urandom);
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      start = 1'b0;
      while (average_q.size() != 0) @(negedge clock);
      repeat (6 + $urandom_range(0, 3)) @(negedge clock);
      csr_valid = 1'b1;
      csr_upper_limit_cm = value;
      do @(posedge clock); while (!csr_ready);
      limit_cm = value;
      @(negedge clock);
      csr_valid = 1'b0;
      csr_upper_limit_cm = LIMIT_BITS'($urandom);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (average_q.size() == 0) begin
            report_mismatch($sformatf("result %0d with none expected", rsp_average_cm));
         end else begin
            expected_cm = average_q.pop_front();
            if (rsp_average_cm !== expected_cm)
               report_mismatch($sformatf("average_cm %0d, expected %0d",
                                         rsp_average_cm, expected_cm));
         end
      end
   end

   initial begin
      logic [LIMIT_BITS-1:0] phase_limit [N_PHASES];
      int                    phase_start;
      int                    items;
      logic                  quiet;
      logic                  to;

      reset = 1'b1;
      start = 1'b0;
      req_sample_cm = '0;
      req_timed_out = 1'b0;
      csr_valid = 1'b0;
      csr_upper_limit_cm = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_LIMIT) begin
            write_limit(DIRECTED[i].value);
         end else begin
            send_word(DIRECTED[i].value, DIRECTED[i].timed_out,
                      DIRECTED[i].has_average, DIRECTED[i].average);
            idle_gap(pick_gap(1'b0));
         end
      end

      phase_limit = '{10'd1023, 10'd0, 10'd1, 10'd50, 10'd0, 10'd0, 10'd500};
      phase_limit[1] = LIMIT_BITS'($urandom_range(3, 1023));
      phase_limit[4] = LIMIT_BITS'($urandom_range(3, 1023));

      foreach (phase_limit[p]) begin
         write_limit(phase_limit[p]);
         phase_start = taken_count;
         items = 0;
         quiet = 1'b0;
         while ((limit_cm > 1 && taken_count - phase_start < WORDS_PER_PHASE) ||
                (limit_cm <= 1 && items < 12)) begin
            if (items % 24 == 0)
               quiet = ($urandom_range(0, 2) == 0);
            to = ($urandom_range(0, 99) < 8);
            send_word(pick_sample(), to, 1'b0, '0);
            idle_gap(pick_gap(quiet));
            items++;
         end
      end

      start = 1'b0;
      while (average_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== range_sample_trimmed_mean_core.f =====
design/rstm_pkg.sv
design/rstm_cell.sv
design/range_sample_trimmed_mean_core.sv
design/rstm_checker.sv
verif/tb_range_sample_trimmed_mean_core.sv
